[rtl/core/lpnal_pkg.sv]
// Shared types, constants and header rewrite for the length-prefixed to start-code converter.
package lpnal_pkg;

    // Block byte counter width (block_left, unit_left).
    localparam int CNT_W = 24;
    // Length field accumulator width (up to four prefix bytes).
    localparam int ACC_W = 32;
    // Width of the length_field_bytes register.
    localparam int LEN_W = 3;
    // Width of the block_bytes input field.
    localparam int BLK_W = 24;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_OVERRUN  = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    // Legal prefix sizes.
    localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO   = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_FOUR  = LEN_W'(4);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

    // Unit header fields.
    localparam logic [4:0] TYPE_IDR        = 5'd5;
    localparam logic [4:0] TYPE_SLICE      = 5'd1;
    localparam logic [1:0] PRIO_DISPOSABLE = 2'd0;
    localparam logic [1:0] PRIO_HIGH       = 2'd2;
    localparam logic [1:0] PRIO_HIGHEST    = 2'd3;

    // Start code 00 00 01: index of the final byte, and its value.
    localparam logic [1:0] SC_LAST_IDX  = 2'd2;
    localparam logic [7:0] SC_LAST_BYTE = 8'h01;
    localparam logic [7:0] SC_ZERO_BYTE = 8'h00;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_UNIT,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_START,
        JOB_ERROR
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } job_t;

    function automatic logic [7:0] fix_header(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b[4:0] == TYPE_IDR) begin
            r = {b[7], PRIO_HIGHEST, b[4:0]};
        end else if (b[4:0] == TYPE_SLICE && b[6:5] != PRIO_DISPOSABLE) begin
            r = {b[7], PRIO_HIGH, b[4:0]};
        end
        return r;
    endfunction

endpackage

[rtl/core/length_prefixed_nal_to_start_code.sv]
// Top level: length-prefixed unit block to start-code delimited byte stream converter.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata: data_byte[7:0], block_bytes[31:8];
//           |     |                    | tuser: cmd (0 start of block, 1 data byte)
//  m_       | out | m_tvalid/m_tready  | tdata: out_byte; tlast: last_of_block;
//           |     |                    | tuser: status
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_data: length_field_bytes (1, 2 or 4)
//
// Flow: one input beat per cycle while the queue has room; each unit byte gives one
// output beat and each completed prefix a three-beat start code, so the input is held
// once the four-entry queue is full. An accepted beat is written into the queue, then
// loaded into the back end's job register, which drives the output.
// Reset: aresetn (sync, active low) idles the parser, empties the queue, sets size 4.
// Stalls: m_tready low fills the queue, then s_tready drops; cfg_ready is always high.
module length_prefixed_nal_to_start_code
    import lpnal_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // input beats
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [7:0] data_byte, [31:8] block_bytes
    input  logic             s_tuser,   // [0] cmd
    // output beats
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    output logic [1:0]       m_tuser,   // [1:0] status
    // configuration
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    // front -> queue
    logic q_push;
    job_t q_job;
    // queue -> back
    job_t head_job;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Parser: tracks block/prefix/unit counts, emits one job per beat at most.
    lpnal_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Decouples the one-beat-per-input front from the multi-beat start codes.
    lpnal_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Output register stage: one beat per cycle while m_tready is high.
    lpnal_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/lpnal_front.sv]
// Front end: input beats, block/length/unit parsing, job generation.
module lpnal_front
    import lpnal_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,
    input  logic             s_tuser,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output job_t             q_job
);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   block_left_reg, block_left_next;
    logic [ACC_W-1:0]   accum_reg, accum_next;
    logic [LEN_W-1:0]   seen_reg, seen_next;
    logic [CNT_W-1:0]   unit_left_reg, unit_left_next;
    logic               hdr_pend_reg, hdr_pend_next;
    logic [LEN_W-1:0]   len_bytes_reg;

    logic               accept;
    logic [7:0]         in_byte;
    logic [BLK_W-1:0]   in_count;
    logic               size_ok;
    logic [CNT_W-1:0]   bl_dec;
    logic [CNT_W-1:0]   ul_dec;
    logic [ACC_W-1:0]   acc_new;
    logic [LEN_W-1:0]   seen_new;
    logic [7:0]         out_b;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign in_byte   = s_tdata[7:0];
    assign in_count  = s_tdata[31:8];

    assign size_ok  = (len_bytes_reg == LEN_ONE) || (len_bytes_reg == LEN_TWO) ||
                      (len_bytes_reg == LEN_FOUR);
    assign bl_dec   = block_left_reg - CNT_W'(1);
    assign ul_dec   = unit_left_reg - CNT_W'(1);
    assign acc_new  = {accum_reg[ACC_W-9:0], in_byte};
    assign seen_new = seen_reg + LEN_W'(1);
    assign out_b    = hdr_pend_reg ? fix_header(in_byte) : in_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            block_left_reg <= '0;
            accum_reg      <= '0;
            seen_reg       <= '0;
            unit_left_reg  <= '0;
            hdr_pend_reg   <= 1'b0;
            len_bytes_reg  <= LEN_RESET;
        end else begin
            phase_reg      <= phase_next;
            block_left_reg <= block_left_next;
            accum_reg      <= accum_next;
            seen_reg       <= seen_next;
            unit_left_reg  <= unit_left_next;
            hdr_pend_reg   <= hdr_pend_next;
            if (cfg_valid && cfg_ready) begin
                len_bytes_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        block_left_next = block_left_reg;
        accum_next      = accum_reg;
        seen_next       = seen_reg;
        unit_left_next  = unit_left_reg;
        hdr_pend_next   = hdr_pend_reg;
        q_push          = 1'b0;
        q_job.kind      = JOB_BYTE;
        q_job.data      = '0;
        q_job.last      = 1'b0;
        q_job.status    = ST_OK;

        if (accept) begin
            if (s_tuser == CMD_START) begin
                block_left_next = CNT_W'(in_count);
                unit_left_next  = '0;
                hdr_pend_next   = 1'b0;
                accum_next      = '0;
                seen_next       = '0;
                phase_next      = (CNT_W'(in_count) != '0) ? PH_LENGTH : PH_IDLE;
            end else begin
                case (phase_reg)
                    PH_LENGTH: begin
                        if (!size_ok) begin
                            q_push       = 1'b1;
                            q_job.kind   = JOB_ERROR;
                            q_job.last   = 1'b1;
                            q_job.status = ST_BAD_SIZE;
                            phase_next   = PH_DROP;
                        end else begin
                            block_left_next = bl_dec;
                            accum_next      = acc_new;
                            seen_next       = seen_new;
                            if (seen_new < len_bytes_reg) begin
                                if (bl_dec == '0) begin
                                    q_push       = 1'b1;
                                    q_job.kind   = JOB_ERROR;
                                    q_job.last   = 1'b1;
                                    q_job.status = ST_TRUNC;
                                    phase_next   = PH_DROP;
                                end
                            end else if (acc_new > ACC_W'(bl_dec)) begin
                                q_push       = 1'b1;
                                q_job.kind   = JOB_ERROR;
                                q_job.last   = 1'b1;
                                q_job.status = ST_OVERRUN;
                                phase_next   = PH_DROP;
                            end else begin
                                unit_left_next = CNT_W'(acc_new);
                                q_push         = 1'b1;
                                q_job.kind     = JOB_START;
                                q_job.last     = (acc_new == '0) && (bl_dec == '0);
                                if (acc_new == '0) begin
                                    hdr_pend_next = 1'b0;
                                    accum_next    = '0;
                                    seen_next     = '0;
                                    phase_next    = (bl_dec == '0) ? PH_IDLE : PH_LENGTH;
                                end else begin
                                    hdr_pend_next = 1'b1;
                                    phase_next    = PH_UNIT;
                                end
                            end
                        end
                    end
                    PH_UNIT: begin
                        hdr_pend_next   = 1'b0;
                        block_left_next = bl_dec;
                        unit_left_next  = ul_dec;
                        q_push          = 1'b1;
                        q_job.kind      = JOB_BYTE;
                        q_job.data      = out_b;
                        q_job.last      = (ul_dec == '0) && (bl_dec == '0);
                        if (ul_dec == '0) begin
                            if (bl_dec == '0) begin
                                phase_next = PH_IDLE;
                            end else begin
                                accum_next = '0;
                                seen_next  = '0;
                                phase_next = PH_LENGTH;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[rtl/core/lpnal_queue.sv]
// Small job queue between the front and back ends.
module lpnal_queue
    import lpnal_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/core/lpnal_back.sv]
// Back end: expands queued jobs into output beats from a held job register.
module lpnal_back
    import lpnal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser
);

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       final_beat;
    logic       advance;

    assign final_beat = (cur_reg.kind != JOB_START) || (idx_reg == SC_LAST_IDX);
    assign advance    = !cur_valid_reg || (m_tready && final_beat);
    assign q_pop      = advance && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (advance) begin
            cur_valid_next = !q_empty;
            cur_next       = head_job;
            idx_next       = '0;
        end else if (m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_comb begin
        case (cur_reg.kind)
            JOB_START: m_tdata = (idx_reg == SC_LAST_IDX) ? SC_LAST_BYTE : SC_ZERO_BYTE;
            default:   m_tdata = cur_reg.data;
        endcase
    end

    assign m_tvalid = cur_valid_reg;
    assign m_tlast  = cur_reg.last && final_beat;
    assign m_tuser  = cur_reg.status;

endmodule
